// File: hw/rtl/ilb_pkg.sv
// ----------------------------------------------------------------------------
// ilb_pkg: shared types and constants for the integer literal converter
// Word formats, literal state, radix and prefix codes, register indexes.
// ----------------------------------------------------------------------------
package ilb_pkg;

	localparam int unsigned MAX_BYTES_DEF = 8;
	localparam int unsigned VALUE_BYTES   = 8;
	localparam int unsigned BYTE_IDX_W    = $clog2(VALUE_BYTES);

	localparam logic CFG_BYTES_IN_USE = 1'b0;
	localparam logic CFG_BIG_ENDIAN   = 1'b1;

	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;
	localparam logic [7:0] CH_UP_A    = 8'h41;
	localparam logic [7:0] CH_UP_B    = 8'h42;
	localparam logic [7:0] CH_UP_F    = 8'h46;
	localparam logic [7:0] CH_UP_X    = 8'h58;
	localparam logic [7:0] CH_LOW_A   = 8'h61;
	localparam logic [7:0] CH_LOW_B   = 8'h62;
	localparam logic [7:0] CH_LOW_F   = 8'h66;
	localparam logic [7:0] CH_LOW_X   = 8'h78;
	localparam logic [4:0] DIGIT_NONE = 5'd16;
	localparam logic [6:0] BITCNT_MAX = 7'd127;

	typedef enum logic [1:0] {
		RADIX_DEC,
		RADIX_BIN,
		RADIX_OCT,
		RADIX_HEX
	} radix_t;

	typedef enum logic [1:0] {
		PH_START,
		PH_AFTER_MINUS,
		PH_AFTER_ZERO,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		logic [7:0] character;
		logic       first;
		logic       last;
	} ilb_in_t;

	typedef struct packed {
		logic [63:0] value;
		logic [3:0]  byte_count;
		logic        overflow;
		logic        bad_digit;
	} ilb_out_t;

	typedef struct packed {
		logic [63:0] acc;
		radix_t      radix;
		phase_t      phase;
		logic [6:0]  bitcnt;
		logic        neg;
		logic        ovf;
		logic        bad;
	} ilb_lit_t;

	localparam ilb_lit_t LIT_CLEAR = '{64'd0, RADIX_DEC, PH_START, 7'd0, 1'b0, 1'b0, 1'b0};

endpackage

// File: hw/rtl/ilb_step.sv
// ----------------------------------------------------------------------------
// ilb_step: per-character literal state update
// Holds the literal state and computes its next value for one character.
// ----------------------------------------------------------------------------
module ilb_step
	import ilb_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     fire,
	input  ilb_in_t  in_s1,
	output ilb_lit_t lit_next
);

	ilb_lit_t    lit_q;
	ilb_lit_t    cur;
	logic        take;
	logic [7:0]  ch;
	logic [4:0]  dig;
	logic [4:0]  limit;
	logic [67:0] dsum;
	logic [63:0] shifted;
	logic        hi_busy;
	logic [2:0]  kbits;
	logic [7:0]  bsum;

	assign ch = in_s1.character;

	always_comb begin
		if (ch >= CH_ZERO && ch <= CH_NINE) begin
			dig = 5'(ch - CH_ZERO);
		end else if (ch >= CH_UP_A && ch <= CH_UP_F) begin
			dig = 5'(ch - CH_UP_A) + 5'd10;
		end else if (ch >= CH_LOW_A && ch <= CH_LOW_F) begin
			dig = 5'(ch - CH_LOW_A) + 5'd10;
		end else begin
			dig = DIGIT_NONE;
		end
	end

	always_comb begin
		cur = in_s1.first ? LIT_CLEAR : lit_q;
		lit_next = cur;
		take = 1'b0;
		unique case (cur.phase)
			PH_START, PH_AFTER_MINUS: begin
				if (ch == CH_MINUS && cur.phase == PH_START) begin
					lit_next.neg = 1'b1;
					lit_next.phase = PH_AFTER_MINUS;
				end else if (ch == CH_ZERO) begin
					lit_next.phase = PH_AFTER_ZERO;
				end else begin
					lit_next.radix = RADIX_DEC;
					lit_next.phase = PH_DIGITS;
					take = 1'b1;
				end
			end
			PH_AFTER_ZERO: begin
				lit_next.phase = PH_DIGITS;
				if (ch == CH_LOW_B || ch == CH_UP_B) begin
					lit_next.radix = RADIX_BIN;
				end else if (ch == CH_LOW_X || ch == CH_UP_X) begin
					lit_next.radix = RADIX_HEX;
				end else begin
					lit_next.radix = RADIX_OCT;
					take = 1'b1;
				end
			end
			PH_DIGITS: begin
				take = 1'b1;
			end
		endcase

		unique case (lit_next.radix)
			RADIX_DEC: begin
				limit = 5'd10;
				kbits = 3'd0;
				hi_busy = 1'b0;
				shifted = cur.acc;
			end
			RADIX_BIN: begin
				limit = 5'd2;
				kbits = 3'd1;
				hi_busy = cur.acc[63];
				shifted = {cur.acc[62:0], dig[0]};
			end
			RADIX_OCT: begin
				limit = 5'd8;
				kbits = 3'd3;
				hi_busy = |cur.acc[63:61];
				shifted = {cur.acc[60:0], dig[2:0]};
			end
			RADIX_HEX: begin
				limit = 5'd16;
				kbits = 3'd4;
				hi_busy = |cur.acc[63:60];
				shifted = {cur.acc[59:0], dig[3:0]};
			end
		endcase

		dsum = {1'b0, cur.acc, 3'b000} + {3'b000, cur.acc, 1'b0} + 68'(dig);
		bsum = {1'b0, cur.bitcnt} + 8'(kbits);

		if (take) begin
			if (dig >= limit) begin
				lit_next.bad = 1'b1;
			end else if (lit_next.radix == RADIX_DEC) begin
				if (|dsum[67:64]) begin
					lit_next.ovf = 1'b1;
					lit_next.acc = '1;
				end else begin
					lit_next.acc = dsum[63:0];
				end
			end else begin
				if (hi_busy) begin
					lit_next.ovf = 1'b1;
					lit_next.acc = '1;
				end else begin
					lit_next.acc = shifted;
				end
				lit_next.bitcnt = bsum[7] ? BITCNT_MAX : bsum[6:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lit_q <= LIT_CLEAR;
		end else if (fire) begin
			lit_q <= in_s1.last ? LIT_CLEAR : lit_next;
		end
	end

endmodule

// File: hw/rtl/ilb_format.sv
// ----------------------------------------------------------------------------
// ilb_format: result formatting for a finished literal
// Sizes, saturates, negates and orders the bytes and counts significant bytes.
// ----------------------------------------------------------------------------
module ilb_format
	import ilb_pkg::*;
#(
	parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
	input  ilb_lit_t   lit,
	input  logic [3:0] bytes_in_use,
	input  logic       big_endian,
	output ilb_out_t   result
);

	logic [3:0]                   size;
	logic [VALUE_BYTES-1:0]       nz;
	logic [VALUE_BYTES-1:0]       en;
	logic [3:0]                   sig;
	logic [3:0]                   whole;
	logic [4:0]                   n_raw;
	logic [4:0]                   n_bits;
	logic                         ovf;
	logic [63:0]                  negv;
	logic [VALUE_BYTES-1:0][7:0]  vb;
	logic [VALUE_BYTES-1:0][7:0]  sb;
	logic [3:0]                   idx [VALUE_BYTES];

	always_comb begin
		if (bytes_in_use == 4'd0) begin
			size = 4'd1;
		end else if (bytes_in_use > 4'(MAX_BYTES)) begin
			size = 4'(MAX_BYTES);
		end else begin
			size = bytes_in_use;
		end
	end

	always_comb begin
		sig = 4'd0;
		for (int i = 0; i < VALUE_BYTES; i++) begin
			nz[i] = |lit.acc[8*i +: 8];
			en[i] = 4'(i) < size;
			if (nz[i]) begin
				sig = 4'(i + 1);
			end
		end
	end

	assign whole = lit.bitcnt[6:3];
	assign n_bits = {1'b0, whole} + ((sig > whole) ? 5'd1 : 5'd0);

	always_comb begin
		if (lit.phase != PH_DIGITS) begin
			n_raw = 5'd1;
		end else if (lit.radix == RADIX_DEC) begin
			n_raw = (sig == 4'd0) ? 5'd1 : {1'b0, sig};
		end else begin
			n_raw = n_bits;
		end
	end

	assign ovf = lit.ovf || (sig > size);
	assign negv = ~lit.acc + 64'd1;

	always_comb begin
		for (int i = 0; i < VALUE_BYTES; i++) begin
			if (!en[i]) begin
				vb[i] = 8'h00;
			end else if (ovf) begin
				vb[i] = 8'hFF;
			end else if (lit.neg) begin
				vb[i] = negv[8*i +: 8];
			end else begin
				vb[i] = lit.acc[8*i +: 8];
			end
		end
		for (int j = 0; j < VALUE_BYTES; j++) begin
			idx[j] = size - 4'd1 - 4'(j);
			sb[j] = en[j] ? vb[idx[j][BYTE_IDX_W-1:0]] : 8'h00;
		end
	end

	always_comb begin
		result.value = big_endian ? sb : vb;
		result.byte_count = (n_raw > {1'b0, size}) ? size : n_raw[3:0];
		result.overflow = ovf;
		result.bad_digit = lit.bad;
	end

endmodule

// File: hw/rtl/integer_literal_to_bytes_core.sv
// ----------------------------------------------------------------------------
// integer_literal_to_bytes_core: ASCII integer literal to binary converter
// Parses a literal one character per word and returns its sized byte image.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Word            Carries
//   in       sink       ilb_in_t        character, first, last
//   out      source     ilb_out_t       value, byte_count, overflow, bad_digit
//   cfg      sink       index + data    bytes_in_use (0), big_endian (1)
//
// One character word is taken per cycle unless a final character waits for the finished-literal register.
// After its last character is taken, a result passes through the finished-literal register and the output register.
// The character register, the finished-literal register and the output
// register form a three-stage pipeline with back-pressure from out_ready.
// Non-final characters never wait on the output side.
// Reset clears all valid flags and the literal state, and sets the configuration to eight bytes, little-endian.
module integer_literal_to_bytes_core
	import ilb_pkg::*;
#(
	parameter int unsigned MAX_BYTES = MAX_BYTES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ilb_in_t    in_word,
	output logic       out_valid,
	input  logic       out_ready,
	output ilb_out_t   out_word,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       cfg_index,
	input  logic [3:0] cfg_data
);

	logic [3:0] size_cfg_q;
	logic       big_endian_q;
	logic       valid_s1;
	ilb_in_t    in_s1;
	logic       valid_s2;
	ilb_lit_t   lit_s2;
	ilb_lit_t   lit_next;
	logic       out_valid_q;
	ilb_out_t   out_word_q;
	ilb_out_t   fmt;
	logic       out_free;
	logic       s2_free;
	logic       step_fire;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_cfg_q <= 4'd8;
			big_endian_q <= 1'b0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BYTES_IN_USE: size_cfg_q <= cfg_data;
				CFG_BIG_ENDIAN:   big_endian_q <= cfg_data[0];
			endcase
		end
	end

	assign out_free = !out_valid_q || out_ready;
	assign s2_free = !valid_s2 || out_free;
	assign step_fire = valid_s1 && (!in_s1.last || s2_free);
	assign in_ready = !valid_s1 || step_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_s1 <= in_word;
		end
	end

	ilb_step u_step (
		.clk      (clk),
		.arst_n   (arst_n),
		.fire     (step_fire),
		.in_s1    (in_s1),
		.lit_next (lit_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= step_fire && in_s1.last;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && step_fire && in_s1.last) begin
			lit_s2 <= lit_next;
		end
	end

	ilb_format #(
		.MAX_BYTES (MAX_BYTES)
	) u_format (
		.lit          (lit_s2),
		.bytes_in_use (size_cfg_q),
		.big_endian   (big_endian_q),
		.result       (fmt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			out_word_q <= fmt;
		end
	end

	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_s1.last |-> in_ready)
		else $error("non-final character stalled the input");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_word.overflow |-> out_word.value[7:0] == 8'hFF)
		else $error("overflow result is not saturated");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_word.byte_count <= 4'(MAX_BYTES))
		else $error("byte count exceeds the maximum size");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !out_free |=> valid_s2 && $stable(lit_s2))
		else $error("finished literal lost while the output stalled");

endmodule
